>>> sv/grouped_free_block_allocator_assert.svh
// ----------------------------------------------------------------------------
// Grouped free-block allocator assertion macros
// Shared concurrent assertion forms for the allocator checker.
// ----------------------------------------------------------------------------
`ifndef GROUPED_FREE_BLOCK_ALLOCATOR_ASSERT_SVH
`define GROUPED_FREE_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define GFBA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("grouped free block allocator: assertion failed");

// Next-cycle implication, disabled during reset.
`define GFBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("grouped free block allocator: assertion failed");

`endif

>>> sv/gfba_pkg.sv
// ----------------------------------------------------------------------------
// Grouped free-block allocator package
// Sizes, codes, command and status groups, and the count clamp.
// ----------------------------------------------------------------------------
package gfba_pkg;

    localparam int NUM_BLOCKS = 1024;
    localparam int GROUP_SIZE = 50;
    localparam int ROW_WORDS  = GROUP_SIZE + 1;

    localparam int BLK_W   = 10;
    localparam int WORD_W  = 11;
    localparam int FC_W    = $clog2(NUM_BLOCKS + 1);
    localparam int CNT_W   = $clog2(GROUP_SIZE + 1);
    localparam int IDX_W   = $clog2(ROW_WORDS + 1);
    localparam int ST_AW   = $clog2(ROW_WORDS);
    localparam int GS_DEPTH = NUM_BLOCKS * ROW_WORDS;
    localparam int GADDR_W = $clog2(GS_DEPTH);

    localparam logic [WORD_W-1:0] END_MARK = {WORD_W{1'b1}};

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef struct packed {
        logic capture;
        logic push;
        logic ignore;
        logic fail;
        logic flush_step;
        logic load_start;
        logic load_step;
        logic pop;
        logic out_load;
    } gfba_cmd_t;

    typedef struct packed {
        logic is_free;
        logic blk_ok;
        logic cnt_full;
        logic cnt_one;
        logic bot_bad;
        logic flush_last;
        logic load_last;
    } gfba_status_t;

    function automatic logic [CNT_W-1:0] clamp_count(input logic [WORD_W-1:0] w);
        logic [CNT_W-1:0] r;
        if (w == '0)
        begin
            r = CNT_W'(1);
        end
        else if (w > WORD_W'(GROUP_SIZE))
        begin
            r = CNT_W'(GROUP_SIZE);
        end
        else
        begin
            r = w[CNT_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> sv/gfba_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module gfba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> sv/gfba_ctrl.sv
// ----------------------------------------------------------------------------
// Grouped free-block allocator controller
// Sequences push, pop, group flush and group load; owns the handshakes.
// ----------------------------------------------------------------------------
module gfba_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  gfba_pkg::gfba_status_t stat,
    output gfba_pkg::gfba_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DISP  = 3'd1;
    localparam logic [2:0] S_POP   = 3'd2;
    localparam logic [2:0] S_FLUSH = 3'd3;
    localparam logic [2:0] S_LOAD  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISP;
                end
            end
            S_DISP:
            begin
                if (stat.is_free)
                begin
                    if (!stat.blk_ok)
                    begin
                        cmd.ignore = 1'b1;
                        state_next = S_DONE;
                    end
                    else if (stat.cnt_full)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        cmd.push   = 1'b1;
                        state_next = S_DONE;
                    end
                end
                else if (stat.cnt_one)
                begin
                    if (stat.bot_bad)
                    begin
                        cmd.fail   = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.load_start = 1'b1;
                        state_next     = S_LOAD;
                    end
                end
                else
                begin
                    state_next = S_POP;
                end
            end
            S_POP:
            begin
                cmd.pop    = 1'b1;
                state_next = S_DONE;
            end
            S_FLUSH:
            begin
                cmd.flush_step = 1'b1;
                if (stat.flush_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_LOAD:
            begin
                cmd.load_step = 1'b1;
                if (stat.load_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> sv/gfba_datapath.sv
// ----------------------------------------------------------------------------
// Grouped free-block allocator datapath
// Head stack, group store, free count, result and output registers.
// ----------------------------------------------------------------------------
module gfba_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gfba_pkg::gfba_cmd_t           cmd,
    output gfba_pkg::gfba_status_t        stat,
    input  logic                          req_type,
    input  logic [gfba_pkg::BLK_W-1:0]    block_number,
    output logic [gfba_pkg::BLK_W-1:0]    given_block,
    output logic                          status,
    output logic [gfba_pkg::FC_W-1:0]     free_total
);

    logic                           req_reg;
    logic [gfba_pkg::BLK_W-1:0]     blk_reg;
    logic [gfba_pkg::GADDR_W-1:0]   base_reg;
    logic [gfba_pkg::IDX_W-1:0]     idx_reg;
    logic [gfba_pkg::CNT_W-1:0]     cnt_reg;
    logic [gfba_pkg::WORD_W-1:0]    bot_reg;
    logic [gfba_pkg::FC_W-1:0]      fc_reg;
    logic [gfba_pkg::BLK_W-1:0]     res_given_reg;
    logic                           res_status_reg;
    logic [gfba_pkg::BLK_W-1:0]     out_given_reg;
    logic                           out_status_reg;
    logic [gfba_pkg::FC_W-1:0]      out_total_reg;

    logic [gfba_pkg::BLK_W-1:0]     mult_blk;
    logic [gfba_pkg::GADDR_W-1:0]   base_next;
    logic [gfba_pkg::FC_W-1:0]      fc_inc;
    logic [gfba_pkg::FC_W-1:0]      fc_dec;
    logic                           pop_bad;

    logic                           st_we;
    logic [gfba_pkg::ST_AW-1:0]     st_waddr;
    logic [gfba_pkg::WORD_W-1:0]    st_wdata;
    logic [gfba_pkg::ST_AW-1:0]     st_raddr;
    logic [gfba_pkg::WORD_W-1:0]    st_rdata;

    logic                           gs_we;
    logic                           gs_re;
    logic [gfba_pkg::GADDR_W-1:0]   gs_addr;
    logic [gfba_pkg::WORD_W-1:0]    gs_wdata;
    logic [gfba_pkg::WORD_W-1:0]    gs_rdata;

    assign mult_blk  = (req_type == gfba_pkg::REQ_FREE) ? block_number
                                                        : bot_reg[gfba_pkg::BLK_W-1:0];
    assign base_next = gfba_pkg::GADDR_W'(
        {{(gfba_pkg::GADDR_W - gfba_pkg::BLK_W){1'b0}}, mult_blk}
        * gfba_pkg::GADDR_W'(gfba_pkg::ROW_WORDS));

    assign fc_inc = (fc_reg < gfba_pkg::FC_W'(gfba_pkg::NUM_BLOCKS)) ? fc_reg + 1'b1 : fc_reg;
    assign fc_dec = (fc_reg != '0) ? fc_reg - 1'b1 : fc_reg;

    assign pop_bad = (st_rdata == gfba_pkg::END_MARK)
                  || (st_rdata >= gfba_pkg::WORD_W'(gfba_pkg::NUM_BLOCKS));

    assign stat.is_free    = (req_reg == gfba_pkg::REQ_FREE);
    assign stat.blk_ok     = gfba_pkg::FC_W'(blk_reg) < gfba_pkg::FC_W'(gfba_pkg::NUM_BLOCKS);
    assign stat.cnt_full   = cnt_reg >= gfba_pkg::CNT_W'(gfba_pkg::GROUP_SIZE);
    assign stat.cnt_one    = cnt_reg == gfba_pkg::CNT_W'(1);
    assign stat.bot_bad    = (bot_reg == gfba_pkg::END_MARK)
                          || (bot_reg >= gfba_pkg::WORD_W'(gfba_pkg::NUM_BLOCKS));
    assign stat.flush_last = idx_reg == gfba_pkg::IDX_W'(gfba_pkg::GROUP_SIZE);
    assign stat.load_last  = idx_reg == gfba_pkg::IDX_W'(gfba_pkg::ROW_WORDS);

    always_comb
    begin
        if (cmd.flush_step)
        begin
            if (idx_reg < gfba_pkg::IDX_W'(gfba_pkg::GROUP_SIZE))
            begin
                st_raddr = gfba_pkg::ST_AW'(idx_reg + 1'b1);
            end
            else
            begin
                st_raddr = '0;
            end
        end
        else
        begin
            st_raddr = gfba_pkg::ST_AW'(cnt_reg);
        end
    end

    assign st_we    = cmd.push || (cmd.load_step && (idx_reg >= gfba_pkg::IDX_W'(3)));
    assign st_waddr = cmd.push ? gfba_pkg::ST_AW'(cnt_reg + 1'b1)
                               : gfba_pkg::ST_AW'(idx_reg - 1'b1);
    assign st_wdata = cmd.push ? gfba_pkg::WORD_W'(blk_reg) : gs_rdata;

    assign gs_addr = base_reg + gfba_pkg::GADDR_W'(idx_reg);
    assign gs_we   = cmd.flush_step;
    assign gs_re   = cmd.load_step && (idx_reg < gfba_pkg::IDX_W'(gfba_pkg::ROW_WORDS));

    always_comb
    begin
        if (idx_reg == '0)
        begin
            gs_wdata = gfba_pkg::WORD_W'(cnt_reg);
        end
        else if (idx_reg == gfba_pkg::IDX_W'(1))
        begin
            gs_wdata = bot_reg;
        end
        else
        begin
            gs_wdata = st_rdata;
        end
    end

    gfba_ram #(
        .WIDTH (gfba_pkg::WORD_W),
        .DEPTH (gfba_pkg::ROW_WORDS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (1'b1),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    gfba_ram #(
        .WIDTH (gfba_pkg::WORD_W),
        .DEPTH (gfba_pkg::GS_DEPTH)
    ) u_group_ram (
        .clk   (clk),
        .we    (gs_we),
        .waddr (gs_addr),
        .wdata (gs_wdata),
        .re    (gs_re),
        .raddr (gs_addr),
        .rdata (gs_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= gfba_pkg::CNT_W'(1);
            bot_reg <= gfba_pkg::END_MARK;
            fc_reg  <= '0;
        end
        else
        begin
            if (cmd.push)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                fc_reg  <= fc_inc;
            end
            if (cmd.flush_step && stat.flush_last)
            begin
                cnt_reg <= gfba_pkg::CNT_W'(1);
                bot_reg <= gfba_pkg::WORD_W'(blk_reg);
                fc_reg  <= fc_inc;
            end
            if (cmd.load_start)
            begin
                fc_reg <= fc_dec;
            end
            if (cmd.load_step && (idx_reg == gfba_pkg::IDX_W'(1)))
            begin
                cnt_reg <= gfba_pkg::clamp_count(gs_rdata);
            end
            if (cmd.load_step && (idx_reg == gfba_pkg::IDX_W'(2)))
            begin
                bot_reg <= gs_rdata;
            end
            if (cmd.pop)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (!pop_bad)
                begin
                    fc_reg <= fc_dec;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg  <= req_type;
            blk_reg  <= block_number;
            base_reg <= base_next;
            idx_reg  <= '0;
        end
        if (cmd.flush_step || cmd.load_step)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.push || cmd.ignore || cmd.flush_step)
        begin
            res_given_reg  <= '0;
            res_status_reg <= 1'b0;
        end
        if (cmd.fail)
        begin
            res_given_reg  <= '0;
            res_status_reg <= 1'b1;
        end
        if (cmd.load_start)
        begin
            res_given_reg  <= bot_reg[gfba_pkg::BLK_W-1:0];
            res_status_reg <= 1'b0;
        end
        if (cmd.pop)
        begin
            res_given_reg  <= pop_bad ? '0 : st_rdata[gfba_pkg::BLK_W-1:0];
            res_status_reg <= pop_bad;
        end
        if (cmd.out_load)
        begin
            out_given_reg  <= res_given_reg;
            out_status_reg <= res_status_reg;
            out_total_reg  <= fc_reg;
        end
    end

    assign given_block = out_given_reg;
    assign status      = out_status_reg;
    assign free_total  = out_total_reg;

endmodule

>>> sv/grouped_free_block_allocator.sv
// Flow: a push, an ignored free or a failed allocate goes from dispatch straight to the result;
// a pop passes through its own pop state; a free that flushes the head stack and an allocate
// that reloads it step through the group store, one word a cycle moving through the group
// store port. One request at a time: a new one is taken only after the last result is loaded
// into the output register, and a waiting result holds the next request.
// Reset (rst_n low, asynchronous): empty list, count one with the end marker, no result.
// ----------------------------------------------------------------------------
// Grouped free-block allocator
// Allocates and frees block numbers through a grouped free-block list.
// ----------------------------------------------------------------------------
module grouped_free_block_allocator (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       req_type,
    input  logic [gfba_pkg::BLK_W-1:0] block_number,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [gfba_pkg::BLK_W-1:0] given_block,
    output logic                       status,
    output logic [gfba_pkg::FC_W-1:0]  free_total
);

    gfba_pkg::gfba_cmd_t    cmd;
    gfba_pkg::gfba_status_t stat;

    gfba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    gfba_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .req_type     (req_type),
        .block_number (block_number),
        .given_block  (given_block),
        .status       (status),
        .free_total   (free_total)
    );

endmodule

>>> sv/gfba_checker.sv
// ----------------------------------------------------------------------------
// Grouped free-block allocator checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "grouped_free_block_allocator_assert.svh"

module gfba_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       req_type,
    input logic [gfba_pkg::BLK_W-1:0] block_number,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [gfba_pkg::BLK_W-1:0] given_block,
    input logic                       status,
    input logic [gfba_pkg::FC_W-1:0]  free_total
);

    localparam logic [gfba_pkg::FC_W-1:0] MAX_FREE = gfba_pkg::FC_W'(gfba_pkg::NUM_BLOCKS);

    `GFBA_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && !in_ready, in_valid && $stable(req_type) && $stable(block_number))

    `GFBA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(given_block) && $stable(status) && $stable(free_total))

    `GFBA_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)

    `GFBA_ASSERT_SAME(a_fail_zero, clk, rst_n, out_valid && status, given_block == '0)

    `GFBA_ASSERT_SAME(a_total_range, clk, rst_n, out_valid, free_total <= MAX_FREE)

endmodule

bind grouped_free_block_allocator gfba_checker u_gfba_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .block_number (block_number),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .given_block  (given_block),
    .status       (status),
    .free_total   (free_total)
);

>>> bench/grouped_free_block_allocator_checker.sv
// ----------------------------------------------------------------------------
// Grouped free-block allocator checker
// Watches both channels of the allocator. Every accepted request is run
// through a local copy of the grouped free list (head stack, saved groups,
// free count), and the predicted beat is queued. Every accepted result beat
// is compared field by field against the oldest queued prediction.
// ----------------------------------------------------------------------------
module grouped_free_block_allocator_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic                       req_type,
    input  logic [gfba_pkg::BLK_W-1:0] block_number,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [gfba_pkg::BLK_W-1:0] given_block,
    input  logic                       status,
    input  logic [gfba_pkg::FC_W-1:0]  free_total,
    output int                         fail_count,
    output int                         outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [gfba_pkg::BLK_W-1:0] blk;
        logic                       no_free;
        logic [gfba_pkg::FC_W-1:0]  total;
    } grant_t;

    logic [gfba_pkg::WORD_W-1:0] stack_words [0:gfba_pkg::ROW_WORDS-1];
    logic [gfba_pkg::WORD_W-1:0] saved_groups [0:gfba_pkg::NUM_BLOCKS-1]
                                              [0:gfba_pkg::ROW_WORDS-1];
    logic [gfba_pkg::FC_W-1:0]   free_blocks;
    grant_t                      expected_grants [$];
    grant_t                      want;

    function automatic int bound_depth(input logic [gfba_pkg::WORD_W-1:0] w);
        int d;
        if (w == '0)
        begin
            d = 1;
        end
        else if (int'(w) > gfba_pkg::GROUP_SIZE)
        begin
            d = gfba_pkg::GROUP_SIZE;
        end
        else
        begin
            d = int'(w);
        end
        return d;
    endfunction

    function automatic grant_t serve_request(input logic kind,
                                             input logic [gfba_pkg::BLK_W-1:0] blk);
        grant_t                      res;
        int                          depth;
        logic [gfba_pkg::WORD_W-1:0] top_word;
        res = '0;
        depth = bound_depth(stack_words[0]);
        if (kind == gfba_pkg::REQ_FREE)
        begin
            if (int'(blk) < gfba_pkg::NUM_BLOCKS)
            begin
                if (depth >= gfba_pkg::GROUP_SIZE)
                begin
                    stack_words[0] = gfba_pkg::WORD_W'(depth);
                    for (int i = 0; i < gfba_pkg::ROW_WORDS; i++)
                    begin
                        saved_groups[blk][i] = stack_words[i];
                    end
                    stack_words[0] = gfba_pkg::WORD_W'(1);
                    stack_words[1] = gfba_pkg::WORD_W'(blk);
                end
                else
                begin
                    depth++;
                    stack_words[0] = gfba_pkg::WORD_W'(depth);
                    stack_words[depth] = gfba_pkg::WORD_W'(blk);
                end
                if (int'(free_blocks) < gfba_pkg::NUM_BLOCKS)
                begin
                    free_blocks++;
                end
            end
        end
        else if (depth == 1)
        begin
            top_word = stack_words[1];
            if (top_word == gfba_pkg::END_MARK || int'(top_word) >= gfba_pkg::NUM_BLOCKS)
            begin
                res.no_free = 1'b1;
            end
            else
            begin
                for (int i = 0; i < gfba_pkg::ROW_WORDS; i++)
                begin
                    stack_words[i] = saved_groups[top_word[gfba_pkg::BLK_W-1:0]][i];
                end
                stack_words[0] = gfba_pkg::WORD_W'(bound_depth(stack_words[0]));
                res.blk = top_word[gfba_pkg::BLK_W-1:0];
                if (free_blocks != '0)
                begin
                    free_blocks--;
                end
            end
        end
        else
        begin
            top_word = stack_words[depth];
            stack_words[0] = gfba_pkg::WORD_W'(depth - 1);
            if (top_word == gfba_pkg::END_MARK || int'(top_word) >= gfba_pkg::NUM_BLOCKS)
            begin
                res.no_free = 1'b1;
            end
            else
            begin
                res.blk = top_word[gfba_pkg::BLK_W-1:0];
                if (free_blocks != '0)
                begin
                    free_blocks--;
                end
            end
        end
        res.total = free_blocks;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < gfba_pkg::ROW_WORDS; i++)
            begin
                stack_words[i] = '0;
            end
            stack_words[0] = gfba_pkg::WORD_W'(1);
            stack_words[1] = gfba_pkg::END_MARK;
            free_blocks = '0;
            expected_grants.delete();
            fail_count = 0;
            outstanding = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_grants.size() == 0)
                begin
                    $error("unexpected result beat: given_block %0d status %0d free_total %0d",
                           given_block, status, free_total);
                    fail_count++;
                end
                else
                begin
                    want = expected_grants.pop_front();
                    if (given_block !== want.blk)
                    begin
                        $error("given_block: expected %0d, actual %0d", want.blk, given_block);
                        fail_count++;
                    end
                    if (status !== want.no_free)
                    begin
                        $error("status: expected %0d, actual %0d", want.no_free, status);
                        fail_count++;
                    end
                    if (free_total !== want.total)
                    begin
                        $error("free_total: expected %0d, actual %0d", want.total, free_total);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                expected_grants.push_back(serve_request(req_type, block_number));
            end
            outstanding = expected_grants.size();
        end
    end

endmodule

>>> bench/grouped_free_block_allocator_tb.sv
// ----------------------------------------------------------------------------
// Grouped free-block allocator testbench
// Drives allocate and free requests into the allocator with random gaps and
// random result back-pressure: a short directed run over the empty list,
// extreme block numbers and double frees, then random phases that fill the
// head stack past its group flushes, saturate the free count and pop back
// through group reloads. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module grouped_free_block_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 1600;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic                          req_type = gfba_pkg::REQ_ALLOC;
    logic [gfba_pkg::BLK_W-1:0]    block_number = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [gfba_pkg::BLK_W-1:0]    given_block;
    logic                          status;
    logic [gfba_pkg::FC_W-1:0]     free_total;
    int                            fail_count;
    int                            outstanding;
    int                            items_sent = 0;
    bit                            sender_quiet = 1'b0;

    grouped_free_block_allocator uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .block_number (block_number),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .given_block  (given_block),
        .status       (status),
        .free_total   (free_total)
    );

    grouped_free_block_allocator_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .block_number (block_number),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .given_block  (given_block),
        .status       (status),
        .free_total   (free_total),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    always #1 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        else if (r < 88)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 97)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(16, 40);
    endfunction

    task automatic send_request(input logic kind, input logic [gfba_pkg::BLK_W-1:0] blk);
        int gap;
        gap = sender_quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        block_number <= blk;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        items_sent++;
    endtask

    task automatic wait_results_done();
        in_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic run_phase(input int count, input int free_pct);
        int                         k;
        int                         r;
        logic                       kind;
        logic [gfba_pkg::BLK_W-1:0] blk;
        for (k = 0; k < count; k++)
        begin
            kind = ($urandom_range(0, 99) < free_pct) ? gfba_pkg::REQ_FREE
                                                      : gfba_pkg::REQ_ALLOC;
            r = $urandom_range(0, 15);
            if (r == 0)
            begin
                blk = '0;
            end
            else if (r == 1)
            begin
                blk = '1;
            end
            else
            begin
                blk = gfba_pkg::BLK_W'($urandom_range(0, gfba_pkg::NUM_BLOCKS - 1));
            end
            send_request(kind, blk);
        end
    endtask

    function automatic int pick_free_pct(input bit alloc_heavy);
        int r;
        r = $urandom_range(0, 2);
        if (r == 0)
        begin
            return alloc_heavy ? 15 : 85;
        end
        else if (r == 1)
        begin
            return 50;
        end
        return alloc_heavy ? 25 : 20;
    endfunction

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rst_n)
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 48)) @(negedge clk);
                if ($urandom_range(0, 3) != 0)
                begin
                    out_ready <= 1'b0;
                    repeat (pick_gap() + 1) @(negedge clk);
                end
            end
        end
    end

    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        bit first_phase;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty list, extreme blocks, double free
        send_request(gfba_pkg::REQ_ALLOC, 10'd0);
        send_request(gfba_pkg::REQ_FREE, 10'd0);
        send_request(gfba_pkg::REQ_FREE, 10'd1023);
        send_request(gfba_pkg::REQ_FREE, 10'd5);
        send_request(gfba_pkg::REQ_FREE, 10'd5);
        send_request(gfba_pkg::REQ_ALLOC, 10'd1023);
        send_request(gfba_pkg::REQ_ALLOC, 10'd0);
        send_request(gfba_pkg::REQ_ALLOC, 10'h2AA);
        send_request(gfba_pkg::REQ_ALLOC, 10'h155);
        send_request(gfba_pkg::REQ_ALLOC, 10'd7);
        send_request(gfba_pkg::REQ_FREE, 10'h2AA);
        send_request(gfba_pkg::REQ_FREE, 10'h155);
        send_request(gfba_pkg::REQ_ALLOC, 10'd0);
        send_request(gfba_pkg::REQ_ALLOC, 10'd1023);
        send_request(gfba_pkg::REQ_ALLOC, 10'd0);

        // mixed traffic through the first flushes and reloads
        first_phase = 1'b1;
        while (items_sent < 200)
        begin
            sender_quiet = ($urandom_range(0, 3) == 0);
            run_phase($urandom_range(20, 90), pick_free_pct(1'b0));
            if (first_phase || $urandom_range(0, 3) == 0)
            begin
                wait_results_done();
            end
            first_phase = 1'b0;
        end

        // saturate the free count
        sender_quiet = ($urandom_range(0, 1) == 0);
        run_phase(gfba_pkg::NUM_BLOCKS + 6, 100);
        wait_results_done();

        // pop back down through group reloads
        while (items_sent < RANDOM_ITEMS)
        begin
            sender_quiet = ($urandom_range(0, 3) == 0);
            run_phase($urandom_range(20, 90), pick_free_pct(1'b1));
            if ($urandom_range(0, 3) == 0)
            begin
                wait_results_done();
            end
        end

        wait_results_done();
        repeat (60) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/gfba_pkg.sv
sv/gfba_ram.sv
sv/gfba_ctrl.sv
sv/gfba_datapath.sv
sv/grouped_free_block_allocator.sv
sv/gfba_checker.sv
bench/grouped_free_block_allocator_checker.sv
bench/grouped_free_block_allocator_tb.sv
